// File: sv/rmgc_pkg.sv
package rmgc_pkg;

	// Fixed field widths
	localparam int BASE_W    = 3;
	localparam int PAT_W     = 32;
	localparam int PAT_BASES = 16;
	localparam int LEN_W     = 5;
	localparam int OUT_W     = 16;
	localparam int IDX_W     = 2;

	// Base codes
	localparam logic [BASE_W-1:0] BASE_A     = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C     = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G     = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T     = 3'd3;
	localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

	// Reset value of the pattern length register
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd6;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_FWD_PATTERN = 2'd0;
	localparam logic [IDX_W-1:0] REG_REV_PATTERN = 2'd1;
	localparam logic [IDX_W-1:0] REG_PATTERN_LEN = 2'd2;

	typedef struct packed {
		logic [BASE_W-1:0] base_code;
		logic              last_base;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] motif_count;
		logic [OUT_W-1:0] forward_count;
		logic [OUT_W-1:0] reverse_count;
		logic [OUT_W-1:0] gc_count;
		logic [OUT_W-1:0] base_total;
	} out_t;

	// Per-base control for the matchers
	typedef struct packed {
		logic adv;
		logic last;
	} step_t;

endpackage

// File: sv/rmgc_matcher.sv
module rmgc_matcher import rmgc_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_BITS  = 16,
	localparam int FW  = $clog2(MAX_PATTERN + 1),
	localparam int CW  = (FW > LEN_W) ? FW : LEN_W,
	localparam int HW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
	localparam int PEW = 2 * ((MAX_PATTERN > PAT_BASES) ? MAX_PATTERN : PAT_BASES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  step_t                              step,
	input  logic [MAX_PATTERN-1:0][BASE_W-1:0] hist,
	input  logic [PAT_W-1:0]                   pattern,
	input  logic [CW-1:0]                      len,
	output logic [COUNT_BITS-1:0]              count_next
);

	logic [FW-1:0]         fresh_q;
	logic [FW-1:0]         fresh_inc;
	logic [FW-1:0]         fresh_next;
	logic [COUNT_BITS-1:0] count_q;
	logic [PEW-1:0]        pat_ext;
	logic                  window_hit;
	logic                  match;

	// Advance the fresh-base count, holding at the top
	assign fresh_inc = (fresh_q < FW'(MAX_PATTERN)) ? fresh_q + 1'b1 : fresh_q;

	// Pattern positions past sixteen read as A
	assign pat_ext = PEW'(pattern);

	// Compare the newest len bases against the pattern, oldest base first
	always_comb begin
		logic [CW-1:0] idx;
		idx        = '0;
		window_hit = (len != '0);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (CW'(i) < len) begin
				idx = len - CW'(i) - 1'b1;
				if (hist[idx[HW-1:0]] != {1'b0, pat_ext[2*i +: 2]})
					window_hit = 1'b0;
			end
		end
	end

	assign match = window_hit && (CW'(fresh_inc) >= len);

	// Restart the matcher after a hit
	assign fresh_next = match ? '0 : fresh_inc;
	assign count_next = (match && (count_q != '1)) ? count_q + 1'b1 : count_q;

	// Update per base, drop state at the end of a read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			count_q <= '0;
		end else if (step.adv) begin
			if (step.last) begin
				fresh_q <= '0;
				count_q <= '0;
			end else begin
				fresh_q <= fresh_next;
				count_q <= count_next;
			end
		end
	end

endmodule

// File: sv/read_motif_and_gc_counter_unit.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready   | in_t : base_code, last_base
// out     | output    | out_valid / out_ready | out_t: motif, fwd, rev, gc, length
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One base per cycle unless stalled: a word is registered, then matched and counted.
// A result word is loaded into the output register as the last base leaves stage 1.
// The input side stalls only while a last base waits on an occupied output register.
// Reset clears the history to "other" codes, all counters, and the registers to defaults.
module read_motif_and_gc_counter_unit import rmgc_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0] cfg_wdata
);

	localparam int FW = $clog2(MAX_PATTERN + 1);
	localparam int CW = (FW > LEN_W) ? FW : LEN_W;

	logic [PAT_W-1:0]                   fwd_pat_q;
	logic [PAT_W-1:0]                   rev_pat_q;
	logic [LEN_W-1:0]                   pat_len_q;
	logic [CW-1:0]                      len_eff;

	logic                               valid_s1;
	in_t                                in_s1;
	logic                               adv_s1;
	step_t                              step;

	logic [MAX_PATTERN-1:0][BASE_W-1:0] hist_q;
	logic [MAX_PATTERN-1:0][BASE_W-1:0] hist_n;
	logic [COUNT_BITS-1:0]              gc_q;
	logic [COUNT_BITS-1:0]              gc_next;
	logic [COUNT_BITS-1:0]              total_q;
	logic [COUNT_BITS-1:0]              total_next;
	logic [COUNT_BITS-1:0]              fwd_count;
	logic [COUNT_BITS-1:0]              rev_count;
	logic [COUNT_BITS-1:0]              motif;
	logic                               is_gc;

	logic                               out_valid_q;
	out_t                               out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_pat_q <= '0;
			rev_pat_q <= '0;
			pat_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FWD_PATTERN: fwd_pat_q <= cfg_wdata;
				REG_REV_PATTERN: rev_pat_q <= cfg_wdata;
				REG_PATTERN_LEN: pat_len_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the pattern length to the history depth
	assign len_eff = (CW'(pat_len_q) > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(pat_len_q);

	// Advance stage 1 unless a last base meets a full output register not being taken
	assign adv_s1   = valid_s1 && (!in_s1.last_base || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign step     = '{adv: adv_s1, last: in_s1.last_base};

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
	end

	// Shift the new base into the history
	always_comb begin
		hist_n[0] = in_s1.base_code;
		for (int j = 1; j < MAX_PATTERN; j++)
			hist_n[j] = hist_q[j-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= {MAX_PATTERN{BASE_OTHER}};
		end else if (adv_s1) begin
			if (in_s1.last_base)
				hist_q <= {MAX_PATTERN{BASE_OTHER}};
			else
				hist_q <= hist_n;
		end
	end

	// Forward and reverse complement matchers
	rmgc_matcher #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_BITS (COUNT_BITS)
	) u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.hist      (hist_n),
		.pattern   (fwd_pat_q),
		.len       (len_eff),
		.count_next(fwd_count)
	);

	rmgc_matcher #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_BITS (COUNT_BITS)
	) u_rev (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.hist      (hist_n),
		.pattern   (rev_pat_q),
		.len       (len_eff),
		.count_next(rev_count)
	);

	// GC and length counters, saturating
	assign is_gc      = (in_s1.base_code == BASE_C) || (in_s1.base_code == BASE_G);
	assign gc_next    = (is_gc && (gc_q != '1)) ? gc_q + 1'b1 : gc_q;
	assign total_next = (total_q != '1) ? total_q + 1'b1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q    <= '0;
			total_q <= '0;
		end else if (adv_s1) begin
			if (in_s1.last_base) begin
				gc_q    <= '0;
				total_q <= '0;
			end else begin
				gc_q    <= gc_next;
				total_q <= total_next;
			end
		end
	end

	assign motif = (fwd_count > rev_count) ? fwd_count : rev_count;

	// Output register: load on the last base, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv_s1 && in_s1.last_base) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_s1.last_base) begin
			out_q.motif_count   <= OUT_W'(motif);
			out_q.forward_count <= OUT_W'(fwd_count);
			out_q.reverse_count <= OUT_W'(rev_count);
			out_q.gc_count      <= OUT_W'(gc_next);
			out_q.base_total    <= OUT_W'(total_next);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rmgc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MOTIF_MAX   = 16;
	localparam int TALLY_MAX   = 16'hFFFF;

	// Index with no register behind it; a write there must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [PAT_W-1:0] cfg_wdata = '0;

	read_motif_and_gc_counter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the block: registers and per-read state
	logic [PAT_W-1:0]  fwd_motif;
	logic [PAT_W-1:0]  rev_motif;
	logic [LEN_W-1:0]  motif_len;
	logic [BASE_W-1:0] recent_bases [MOTIF_MAX];
	logic [4:0]        fwd_fresh;
	logic [4:0]        rev_fresh;
	logic [OUT_W-1:0]  fwd_hits;
	logic [OUT_W-1:0]  rev_hits;
	logic [OUT_W-1:0]  gc_tally;
	logic [OUT_W-1:0]  base_tally;

	out_t read_summaries [$];
	out_t oldest_summary;

	int          errors        = 0;
	int          cycles        = 0;
	int          bases_sent    = 0;
	int          reads_sent    = 0;
	int          summaries_ok  = 0;
	int          stall_cycles  = 0;
	int unsigned hold_left     = 0;
	int unsigned stall_left    = 0;
	bit          calm          = 1'b0;
	bit          send_gaps     = 1'b0;
	bit          recv_gaps     = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reads pending", cycles,
				read_summaries.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && !in_ready)
			stall_cycles++;
	end

	function automatic int eff_len();
		return (motif_len > MOTIF_MAX) ? MOTIF_MAX : int'(motif_len);
	endfunction

	function automatic logic [BASE_W-1:0] motif_base(logic [PAT_W-1:0] pat, int pos);
		return {1'b0, pat[2*pos +: 2]};
	endfunction

	function automatic logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
		return (v == TALLY_MAX) ? v : v + 1'b1;
	endfunction

	// Newest base lines up with the last motif base
	function automatic bit window_hit(logic [PAT_W-1:0] pat, int len);
		if (len == 0)
			return 1'b0;
		for (int i = 0; i < len; i++) begin
			if (recent_bases[len-1-i] !== motif_base(pat, i))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void clear_read();
		for (int i = 0; i < MOTIF_MAX; i++)
			recent_bases[i] = BASE_OTHER;
		fwd_fresh  = '0;
		rev_fresh  = '0;
		fwd_hits   = '0;
		rev_hits   = '0;
		gc_tally   = '0;
		base_tally = '0;
	endfunction

	// Advance the mirror by one base; return 1 with the summary on the last base
	function automatic bit tally_base(in_t w, output out_t r);
		int len;
		len = eff_len();
		r = '0;
		for (int i = MOTIF_MAX - 1; i > 0; i--)
			recent_bases[i] = recent_bases[i-1];
		recent_bases[0] = w.base_code;
		if (fwd_fresh < MOTIF_MAX)
			fwd_fresh++;
		if (rev_fresh < MOTIF_MAX)
			rev_fresh++;
		if (len != 0 && fwd_fresh >= len && window_hit(fwd_motif, len)) begin
			fwd_hits  = bump(fwd_hits);
			fwd_fresh = '0;
		end
		if (len != 0 && rev_fresh >= len && window_hit(rev_motif, len)) begin
			rev_hits  = bump(rev_hits);
			rev_fresh = '0;
		end
		if (w.base_code == BASE_C || w.base_code == BASE_G)
			gc_tally = bump(gc_tally);
		base_tally = bump(base_tally);
		if (!w.last_base)
			return 1'b0;
		r.motif_count   = (fwd_hits > rev_hits) ? fwd_hits : rev_hits;
		r.forward_count = fwd_hits;
		r.reverse_count = rev_hits;
		r.gc_count      = gc_tally;
		r.base_total    = base_tally;
		clear_read();
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic check_field(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		if (got !== want)
			report_mismatch(what, int'(got), int'(want));
	endtask

	// Compare each accepted result word with the oldest pending summary
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (read_summaries.size() == 0) begin
				report_mismatch("result word with no read pending",
					int'(out_data.base_total), 0);
			end else begin
				oldest_summary = read_summaries.pop_front();
				check_field("motif_count", out_data.motif_count, oldest_summary.motif_count);
				check_field("forward_count", out_data.forward_count,
					oldest_summary.forward_count);
				check_field("reverse_count", out_data.reverse_count,
					oldest_summary.reverse_count);
				check_field("gc_count", out_data.gc_count, oldest_summary.gc_count);
				check_field("base_total", out_data.base_total, oldest_summary.base_total);
				summaries_ok++;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && recv_gaps && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one word and hold it until taken; valid stays high for the next word
	task automatic send_base(in_t w);
		out_t r;
		if (!calm && send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bases_sent++;
		if (w.last_base)
			reads_sent++;
		if (tally_base(w, r))
			read_summaries.insert(read_summaries.size(), r);
	endtask

	// Drop valid and wait until every summary is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (read_summaries.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [PAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_FWD_PATTERN: fwd_motif = data;
			REG_REV_PATTERN: rev_motif = data;
			REG_PATTERN_LEN: motif_len = data[LEN_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_motifs(logic [PAT_W-1:0] fwd, logic [PAT_W-1:0] rev, int len);
		write_reg(REG_FWD_PATTERN, fwd);
		write_reg(REG_REV_PATTERN, rev);
		write_reg(REG_PATTERN_LEN, PAT_W'(len));
	endtask

	task automatic send_code(logic [BASE_W-1:0] code, bit last);
		in_t w;
		w.base_code = code;
		w.last_base = last;
		send_base(w);
	endtask

	// Build a read from motif copies, damaged copies and loose bases
	task automatic send_read(int n);
		in_t              w;
		int               k;
		int               c;
		int               len;
		int               pick;
		logic [PAT_W-1:0] pat;
		k   = 0;
		len = eff_len();
		while (k < n) begin
			pick = $urandom_range(0, 9);
			if (len != 0 && pick < 6) begin
				pat = (pick < 3) ? fwd_motif : rev_motif;
				for (c = 0; c < len && k < n; c++) begin
					w.base_code = motif_base(pat, c);
					if ($urandom_range(0, 19) == 0)
						w.base_code = BASE_W'($urandom_range(0, 7));
					w.last_base = (k == n - 1);
					send_base(w);
					k++;
				end
			end else begin
				if ($urandom_range(0, 7) == 0)
					w.base_code = BASE_W'($urandom_range(4, 7));
				else
					w.base_code = BASE_W'($urandom_range(0, 3));
				w.last_base = (k == n - 1);
				send_base(w);
				k++;
			end
		end
	endtask

	function automatic logic [PAT_W-1:0] pick_pattern();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Reverse complement of the forward motif over len bases, random above
	function automatic logic [PAT_W-1:0] rev_complement(logic [PAT_W-1:0] fwd, int len);
		logic [PAT_W-1:0] rc;
		rc = $urandom();
		for (int i = 0; i < len; i++)
			rc[2*i +: 2] = ~fwd[2*(len-1-i) +: 2];
		return rc;
	endfunction

	// Reset values: all-A motifs of six bases match once in seven A
	task automatic test_default_registers();
		for (int i = 0; i < 7; i++)
			send_code(BASE_A, i == 6);
		drain();
	endtask

	// Codes 4 to 7 never match nor count as G/C, even when their low bits would
	task automatic test_other_symbols();
		set_motifs(32'hFFFF_FFF1, 32'hAAAA_AAA2, 1);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		for (int i = 4; i < 8; i++)
			send_code(BASE_W'(i), 1'b0);
		send_code(BASE_C, 1'b0);
		send_code(BASE_G, 1'b0);
		send_code(BASE_T, 1'b0);
		send_code(BASE_A, 1'b1);
		drain();
	endtask

	// Zero motif length never matches; a read may be a single base
	task automatic test_short_reads();
		set_motifs('0, '0, 0);
		send_code(BASE_A, 1'b0);
		send_code(BASE_A, 1'b0);
		send_code(BASE_A, 1'b1);
		send_code(BASE_C, 1'b1);
		drain();
	endtask

	// Phases of random reads, each with fresh motifs; extreme lengths come first
	task automatic test_random_reads(int budget);
		int               start;
		int               ph;
		int               len;
		int               n;
		logic [PAT_W-1:0] fwd;
		logic [PAT_W-1:0] rev;
		start = bases_sent;
		ph    = 0;
		while (bases_sent - start < budget) begin
			case (ph)
				0: len = 16;
				1: len = 31;
				2: len = 0;
				3: len = 17;
				default: len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, 6);
			endcase
			fwd = (ph == 0) ? '1 : pick_pattern();
			if ($urandom_range(0, 1) == 0)
				rev = rev_complement(fwd, (len > MOTIF_MAX) ? MOTIF_MAX : len);
			else
				rev = pick_pattern();
			set_motifs(fwd, rev, len);
			send_gaps = $urandom_range(0, 2) != 0;
			recv_gaps = $urandom_range(0, 2) != 0;
			for (int r = 0; r < 8; r++) begin
				if ($urandom_range(0, 15) == 0)
					n = $urandom_range(1, 80);
				else
					n = $urandom_range(1, 3 * eff_len() + 6);
				send_read(n);
			end
			drain();
			ph++;
		end
	endtask

	// Hold the receiver off while short reads keep coming, so the input stalls
	task automatic test_output_backpressure();
		send_gaps = 1'b0;
		set_motifs(32'h0000_0E4, 32'h0000_01B, 3);
		hold_left = 400;
		for (int r = 0; r < 30; r++)
			send_read($urandom_range(1, 3));
		drain();
	endtask

	initial begin
		clear_read();
		fwd_motif = '0;
		rev_motif = '0;
		motif_len = LEN_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_other_symbols();
		test_short_reads();
		test_random_reads(650);
		test_output_backpressure();
		calm = 1'b1;
		test_random_reads(100);

		drain();
		repeat (10) @(posedge clk);
		$display("%0d reads, %0d bases, %0d results checked, %0d input stall cycles",
			reads_sent, bases_sent, summaries_ok, stall_cycles);
		$display("motif lengths 0 to 31, other symbols, single-base reads, output hold-off");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: read_motif_and_gc_counter_unit.f
sv/rmgc_pkg.sv
sv/rmgc_matcher.sv
sv/read_motif_and_gc_counter_unit.sv
tb/testbench.sv
